[rtl/core/one_wire_temperature_reader_unit_defines.svh]
// Assertion macros used by the single-wire reader sequencer.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ONE_WIRE_TEMPERATURE_READER_UNIT_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OWTR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OWTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/owtr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_pkg
// Types, step codes, bus commands and decode helpers for the single-wire
// temperature reader.
// ----------------------------------------------------------------------------
package owtr_pkg;

    // Width of the longest timing register
    localparam int CFG_TIME_W = 20;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RESET_LOW      = 3'd0;
    localparam logic [2:0] REG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [2:0] REG_SLOT_START     = 3'd3;
    localparam logic [2:0] REG_SLOT_BODY      = 3'd4;
    localparam logic [2:0] REG_CONV_WAIT      = 3'd5;
    localparam logic [2:0] REG_ABSENT_HOLD    = 3'd6;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // Last bit position within a byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Sequence step codes
    typedef logic [4:0] step_t;
    localparam step_t ST_IDLE          = 5'd0;
    localparam step_t ST_RLOW_A        = 5'd1;
    localparam step_t ST_RWAIT_A       = 5'd2;
    localparam step_t ST_RTAIL_A       = 5'd3;
    localparam step_t ST_RLOW_B        = 5'd4;
    localparam step_t ST_RWAIT_B       = 5'd5;
    localparam step_t ST_RTAIL_B       = 5'd6;
    localparam step_t ST_WSTART_SKIP_B = 5'd7;
    localparam step_t ST_WBODY_SKIP_B  = 5'd8;
    localparam step_t ST_WSTART_CONV   = 5'd9;
    localparam step_t ST_WBODY_CONV    = 5'd10;
    localparam step_t ST_CONV_WAIT     = 5'd11;
    localparam step_t ST_RLOW_C        = 5'd12;
    localparam step_t ST_RWAIT_C       = 5'd13;
    localparam step_t ST_RTAIL_C       = 5'd14;
    localparam step_t ST_WSTART_SKIP_C = 5'd15;
    localparam step_t ST_WBODY_SKIP_C  = 5'd16;
    localparam step_t ST_WSTART_READ   = 5'd17;
    localparam step_t ST_WBODY_READ    = 5'd18;
    localparam step_t ST_RSTART_LO     = 5'd19;
    localparam step_t ST_RBODY_LO      = 5'd20;
    localparam step_t ST_RSTART_HI     = 5'd21;
    localparam step_t ST_RBODY_HI      = 5'd22;
    localparam step_t ST_HOLD          = 5'd23;

    // Class of a step: decides its duration and line behavior
    typedef enum logic [3:0] {
        K_NONE,
        K_RLOW,
        K_RWAIT,
        K_RTAIL,
        K_WSTART,
        K_WBODY,
        K_CONV,
        K_RSTART,
        K_RBODY,
        K_HOLD
    } kind_t;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [9:0]            reset_low_time;
        logic [7:0]            presence_sample_time;
        logic [9:0]            reset_tail_time;
        logic [3:0]            slot_start_time;
        logic [7:0]            slot_body_time;
        logic [CFG_TIME_W-1:0] conversion_wait_time;
        logic [CFG_TIME_W-1:0] absent_hold_time;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               device_absent;
        logic signed [15:0] temperature;
    } res_t;

    function automatic kind_t kind_of(input step_t s);
        kind_t k;
        unique case (s) inside
            ST_RLOW_A, ST_RLOW_B, ST_RLOW_C:                         k = K_RLOW;
            ST_RWAIT_A, ST_RWAIT_B, ST_RWAIT_C:                      k = K_RWAIT;
            ST_RTAIL_A, ST_RTAIL_B, ST_RTAIL_C:                      k = K_RTAIL;
            ST_WSTART_SKIP_B, ST_WSTART_CONV,
            ST_WSTART_SKIP_C, ST_WSTART_READ:                        k = K_WSTART;
            ST_WBODY_SKIP_B, ST_WBODY_CONV,
            ST_WBODY_SKIP_C, ST_WBODY_READ:                          k = K_WBODY;
            ST_CONV_WAIT:                                            k = K_CONV;
            ST_RSTART_LO, ST_RSTART_HI:                              k = K_RSTART;
            ST_RBODY_LO, ST_RBODY_HI:                                k = K_RBODY;
            ST_HOLD:                                                 k = K_HOLD;
            default:                                                 k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] command_of(input step_t s);
        logic [7:0] c;
        if (s == ST_WSTART_CONV)
        begin
            c = CMD_CONVERT;
        end
        else if (s == ST_WSTART_READ)
        begin
            c = CMD_READ_PAD;
        end
        else
        begin
            c = CMD_SKIP_ROM;
        end
        return c;
    endfunction

endpackage

[rtl/core/owtr_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_chan_if
// Valid/ready channels of the reader: tick beats in, result beats out.
// ----------------------------------------------------------------------------
interface owtr_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface owtr_res_if;
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               device_absent;
    logic signed [15:0] temperature;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output device_absent, output temperature, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input device_absent, input temperature, output ready);
endinterface

[rtl/core/owtr_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_cfg
// APB-style register file holding the bus timing values.
// ----------------------------------------------------------------------------
module owtr_cfg
    import owtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [9:0]            reset_low_reg;
    logic [7:0]            presence_sample_reg;
    logic [9:0]            reset_tail_reg;
    logic [3:0]            slot_start_reg;
    logic [7:0]            slot_body_reg;
    logic [CFG_TIME_W-1:0] conv_wait_reg;
    logic [CFG_TIME_W-1:0] absent_hold_reg;
    logic                  wr_en;
    logic [2:0]            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg       <= 10'd480;
            presence_sample_reg <= 8'd60;
            reset_tail_reg      <= 10'd420;
            slot_start_reg      <= 4'd2;
            slot_body_reg       <= 8'd60;
            conv_wait_reg       <= 20'd750000;
            absent_hold_reg     <= 20'd500000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RESET_LOW:       reset_low_reg       <= pwdata[9:0];
                REG_PRESENCE_SAMPLE: presence_sample_reg <= pwdata[7:0];
                REG_RESET_TAIL:      reset_tail_reg      <= pwdata[9:0];
                REG_SLOT_START:      slot_start_reg      <= pwdata[3:0];
                REG_SLOT_BODY:       slot_body_reg       <= pwdata[7:0];
                REG_CONV_WAIT:       conv_wait_reg       <= pwdata[CFG_TIME_W-1:0];
                REG_ABSENT_HOLD:     absent_hold_reg     <= pwdata[CFG_TIME_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_RESET_LOW:       prdata = {22'd0, reset_low_reg};
            REG_PRESENCE_SAMPLE: prdata = {24'd0, presence_sample_reg};
            REG_RESET_TAIL:      prdata = {22'd0, reset_tail_reg};
            REG_SLOT_START:      prdata = {28'd0, slot_start_reg};
            REG_SLOT_BODY:       prdata = {24'd0, slot_body_reg};
            REG_CONV_WAIT:       prdata = {12'd0, conv_wait_reg};
            REG_ABSENT_HOLD:     prdata = {12'd0, absent_hold_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.reset_low_time       = reset_low_reg;
    assign cfg.presence_sample_time = presence_sample_reg;
    assign cfg.reset_tail_time      = reset_tail_reg;
    assign cfg.slot_start_time      = slot_start_reg;
    assign cfg.slot_body_time       = slot_body_reg;
    assign cfg.conversion_wait_time = conv_wait_reg;
    assign cfg.absent_hold_time     = absent_hold_reg;

endmodule

[rtl/core/owtr_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_seq
// Bus sequencer: step, tick timer, bit counter and shift byte, advanced by
// one tick per accepted tick beat. Emits the result of that tick.
// ----------------------------------------------------------------------------
`include "one_wire_temperature_reader_unit_defines.svh"

module owtr_seq
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 20
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic advance,
    input  logic start_req,
    input  logic line_level,
    output res_t res
);

    // Duration compare width: holds the timer plus one and the capped duration
    localparam int DurW = (TIMER_BITS > CFG_TIME_W ? TIMER_BITS : CFG_TIME_W) + 1;

    step_t                 step_reg,   step_next;
    logic [TIMER_BITS-1:0] timer_reg,  timer_next;
    logic [2:0]            bit_reg,    bit_next;
    logic [7:0]            shift_reg,  shift_next;
    logic [7:0]            low_reg,    low_next;
    logic [15:0]           result_reg, result_next;
    logic                  absent_reg, absent_next;

    step_t                 step_eff;
    logic [TIMER_BITS-1:0] timer_eff;
    kind_t                 kind_eff;
    logic [CFG_TIME_W-1:0] dur_raw;
    logic [DurW-1:0]       dur;
    logic                  last;
    logic                  drive;
    logic                  done;
    logic                  go;
    step_t                 go_step;
    kind_t                 go_kind;

    // Leave idle on a start; unused codes fall back to idle
    always_comb
    begin
        step_eff  = step_reg;
        timer_eff = timer_reg;
        kind_eff  = kind_of(step_reg);
        if (kind_eff == K_NONE)
        begin
            step_eff = ST_IDLE;
            if (start_req)
            begin
                step_eff  = ST_RLOW_A;
                timer_eff = '0;
                kind_eff  = K_RLOW;
            end
        end
    end

    // Pick the step duration: zero counts as one tick, cap at the timer range
    always_comb
    begin
        case (kind_eff)
            K_RLOW:           dur_raw = CFG_TIME_W'(cfg.reset_low_time);
            K_RWAIT:          dur_raw = CFG_TIME_W'(cfg.presence_sample_time);
            K_RTAIL:          dur_raw = CFG_TIME_W'(cfg.reset_tail_time);
            K_WSTART,
            K_RSTART:         dur_raw = CFG_TIME_W'(cfg.slot_start_time);
            K_WBODY,
            K_RBODY:          dur_raw = CFG_TIME_W'(cfg.slot_body_time);
            K_CONV:           dur_raw = cfg.conversion_wait_time;
            K_HOLD:           dur_raw = cfg.absent_hold_time;
            default:          dur_raw = CFG_TIME_W'(1);
        endcase
        dur = DurW'(dur_raw);
        if (dur == '0)
        begin
            dur = DurW'(1);
        end
        if (dur > (DurW'(1) << TIMER_BITS))
        begin
            dur = DurW'(1) << TIMER_BITS;
        end
        last = (DurW'(timer_eff) + DurW'(1)) >= dur;
    end

    // Work out one tick of the sequence
    always_comb
    begin
        step_next   = step_eff;
        timer_next  = timer_eff;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        low_next    = low_reg;
        result_next = result_reg;
        absent_next = absent_reg;
        drive       = 1'b0;
        done        = 1'b0;
        go          = 1'b0;
        go_step     = ST_IDLE;

        if (kind_eff != K_NONE)
        begin
            // Line behavior of this tick
            case (kind_eff)
                K_RLOW,
                K_WSTART,
                K_RSTART:
                begin
                    drive = 1'b1;
                end
                K_RWAIT:
                begin
                    if (last && step_eff == ST_RWAIT_A)
                    begin
                        absent_next = line_level;
                    end
                end
                K_WBODY:
                begin
                    drive = ~shift_reg[0];
                end
                K_RBODY:
                begin
                    if (timer_eff == '0)
                    begin
                        shift_next = {line_level, shift_reg[7:1]};
                    end
                end
                default:
                begin
                end
            endcase

            // Advance timer or step
            if (!last)
            begin
                timer_next = timer_eff + {{(TIMER_BITS-1){1'b0}}, 1'b1};
            end
            else if (kind_eff == K_WBODY || kind_eff == K_RBODY)
            begin
                if (bit_reg != LAST_BIT)
                begin
                    bit_next   = bit_reg + 3'd1;
                    step_next  = step_eff - 5'd1;
                    timer_next = '0;
                    if (kind_eff == K_WBODY)
                    begin
                        shift_next = shift_next >> 1;
                    end
                end
                else
                begin
                    bit_next = '0;
                    go       = 1'b1;
                    if (step_eff == ST_RBODY_LO)
                    begin
                        low_next = shift_next;
                        go_step  = ST_RSTART_HI;
                    end
                    else if (step_eff == ST_RBODY_HI)
                    begin
                        result_next = {shift_next, low_reg};
                        done        = 1'b1;
                        go_step     = ST_IDLE;
                    end
                    else
                    begin
                        go_step = step_eff + 5'd1;
                    end
                end
            end
            else if (step_eff == ST_RTAIL_A)
            begin
                go = 1'b1;
                if (absent_reg)
                begin
                    go_step = (cfg.absent_hold_time != '0) ? ST_HOLD : ST_IDLE;
                end
                else
                begin
                    go_step = ST_RLOW_B;
                end
            end
            else if (step_eff == ST_HOLD)
            begin
                go      = 1'b1;
                go_step = ST_IDLE;
            end
            else
            begin
                go      = 1'b1;
                go_step = step_eff + 5'd1;
            end
        end

        // Enter a new step: clear the timer, load the command or clear the byte
        go_kind = kind_of(go_step);
        if (go)
        begin
            step_next  = go_step;
            timer_next = '0;
            if (go_kind == K_WSTART)
            begin
                shift_next = command_of(go_step);
            end
            else if (go_kind == K_RSTART)
            begin
                shift_next = '0;
            end
        end
    end

    // Commit one tick per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= ST_IDLE;
            timer_reg  <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            low_reg    <= '0;
            result_reg <= '0;
            absent_reg <= 1'b0;
        end
        else if (advance)
        begin
            step_reg   <= step_next;
            timer_reg  <= timer_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            low_reg    <= low_next;
            result_reg <= result_next;
            absent_reg <= absent_next;
        end
    end

    assign res.drive_low     = drive;
    assign res.busy_res      = (kind_eff != K_NONE);
    assign res.done_res      = done;
    assign res.device_absent = absent_next;
    assign res.temperature   = result_next;

    `OWTR_ASSERT_SAME(a_done_in_high_byte, res.done_res,
        (step_reg == ST_RBODY_HI) && (bit_reg == LAST_BIT),
        "done raised outside the last bit of the high byte")
    `OWTR_ASSERT_NEXT(a_hold_without_beat, !advance,
        $stable(step_reg) && $stable(timer_reg) && $stable(result_reg),
        "sequencer state moved without a tick beat")
    `OWTR_ASSERT_NEXT(a_idle_stays_idle, advance && (step_reg == ST_IDLE) && !start_req,
        step_reg == ST_IDLE,
        "sequencer left idle without a start request")
    `OWTR_ASSERT_SAME(a_bit_count_in_slot, bit_reg != '0,
        (kind_of(step_reg) == K_WSTART) || (kind_of(step_reg) == K_WBODY) ||
        (kind_of(step_reg) == K_RSTART) || (kind_of(step_reg) == K_RBODY),
        "bit counter nonzero outside a bit slot")

endmodule

[rtl/core/one_wire_temperature_reader_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_unit
// Single-wire bus master that runs a temperature conversion and reads back
// the signed result, one microsecond tick beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   tick_in carries one beat per bus tick: start_req asks for a measurement
//   (ignored while busy), line_level is the sampled bus level of that tick.
//   res_out returns exactly one beat per tick beat: drive_low for the bus
//   driver, busy_res, done_res on the tick the second byte is read,
//   device_absent and the last temperature in sixteenths of a degree.
//   A tick accepted at a clock edge has its result in the output register after
//   that edge. Throughput is one tick per cycle while res_out is not stalled;
//   the sequencer state and the output register are each one register deep.
//   When res_out is stalled with a result held, tick_in.ready drops until
//   the result is taken; nothing is lost and state does not move.
//   Reset leaves the sequencer idle, the output register empty and the
//   timing registers at their default values. Program timing through the
//   APB port only while no sequence runs.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader_unit
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    owtr_tick_if.sink         tick_in,
    owtr_res_if.source        res_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t cfg;
    res_t res_comb;
    res_t res_reg;
    logic out_valid_reg;
    logic advance;

    owtr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a tick whenever the output slot is free or being drained
    assign tick_in.ready = !out_valid_reg || res_out.ready;
    assign advance       = tick_in.valid && tick_in.ready;

    owtr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (advance),
        .start_req  (tick_in.start_req),
        .line_level (tick_in.line_level),
        .res        (res_comb)
    );

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.drive_low     = res_reg.drive_low;
    assign res_out.busy_res      = res_reg.busy_res;
    assign res_out.done_res      = res_reg.done_res;
    assign res_out.device_absent = res_reg.device_absent;
    assign res_out.temperature   = res_reg.temperature;

endmodule
